[rtl/smqs_pkg.sv]
// smqs_pkg: shared types, constants and decode tables for the stepper move queue sequencer
// no dependencies; imported by smqs_core, smqs_outbuf, smqs_checker and the top level
`default_nettype none

package smqs_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int MOTOR_COUNT = 6;
	localparam int CODE_W = 5;
	localparam int KIND_W = 3;
	localparam int PEND_W = 7;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CODE_W-1:0] MAX_CODE = 5'd18;
	localparam logic [MOTOR_COUNT-1:0] ALL_MOTORS = '1;

	localparam logic [15:0] HALF_PERIOD_RESET = 16'd300;
	localparam logic [15:0] GAP_RESET = 16'd10000;
	localparam logic [11:0] QUARTER_RESET = 12'd200;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK  = 3'd0,
		KIND_PUSH  = 3'd1,
		KIND_START = 3'd2,
		KIND_STOP  = 3'd3,
		KIND_CLEAR = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HALF_PERIOD = 2'd0,
		CFG_GAP         = 2'd1,
		CFG_QUARTER     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CODE_W-1:0] move_code;
	} cmd_t;

	typedef struct packed {
		logic [MOTOR_COUNT-1:0] step_lines;
		logic [MOTOR_COUNT-1:0] dir_lines;
		logic [MOTOR_COUNT-1:0] enable_n_lines;
		logic                   running;
		logic                   busy_res;
		logic [PEND_W-1:0]      pending_moves;
		logic                   push_dropped;
	} rsp_t;

	// motor wired to each face: D 0, F 1, L 2, R 3, B 4, U 5
	function automatic logic [2:0] code_motor(input logic [CODE_W-1:0] code);
		logic [2:0] m;
		case (code)
			5'd1, 5'd2, 5'd3:    m = 3'd5;
			5'd4, 5'd5, 5'd6:    m = 3'd0;
			5'd7, 5'd8, 5'd9:    m = 3'd2;
			5'd10, 5'd11, 5'd12: m = 3'd3;
			5'd13, 5'd14, 5'd15: m = 3'd1;
			5'd16, 5'd17, 5'd18: m = 3'd4;
			default:             m = 3'd0;
		endcase
		return m;
	endfunction

	function automatic logic code_dir(input logic [CODE_W-1:0] code);
		logic d;
		case (code)
			5'd2, 5'd4, 5'd6, 5'd8, 5'd11, 5'd13,
			5'd15, 5'd16, 5'd18: d = 1'b1;
			default:             d = 1'b0;
		endcase
		return d;
	endfunction

	// half turns are the codes that are multiples of three
	function automatic logic code_half(input logic [CODE_W-1:0] code);
		logic h;
		case (code)
			5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18: h = 1'b1;
			default:                                h = 1'b0;
		endcase
		return h;
	endfunction

	// motor index modulo the motor count, as a one-hot line mask
	function automatic logic [MOTOR_COUNT-1:0] motor_bit(input logic [2:0] motor);
		logic [MOTOR_COUNT-1:0] b;
		case (motor)
			3'd0:    b = 6'b000001;
			3'd1:    b = 6'b000010;
			3'd2:    b = 6'b000100;
			3'd3:    b = 6'b001000;
			3'd4:    b = 6'b010000;
			3'd5:    b = 6'b100000;
			3'd6:    b = 6'b000001;
			default: b = 6'b000010;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

[rtl/stepper_move_queue_sequencer.sv]
// stepper_move_queue_sequencer: top level of the six-motor move queue sequencer
// depends on smqs_pkg, smqs_core (with smqs_ram) and smqs_outbuf
//
//   channel  signals                          flow
//   cmd      cmd_valid, cmd_stall, cmd        tick / push / start / stop / clear requests
//   rsp      rsp_valid, rsp_stall, rsp        one status request per cmd request
//   cfg      cfg_valid, cfg_ready, cfg_index, register writes, always ready
//            cfg_data
//
// one cmd request per clock while cmd_stall is low; its status is on rsp the
// following cycle unless rsp is held; the state update is a single registered pass;
// the queue head is prefetched from the move RAM so a move can start on any tick
// a result register and a skid register sit on rsp: a request taken while rsp is
// stalled fills the skid register, and cmd_stall stays high until rsp takes a request
// arst_n clears all control state and loads the register reset values, not the move RAM
`default_nettype none

module stepper_move_queue_sequencer #(
	parameter int QUEUE_DEPTH = smqs_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cmd_valid,
	output logic                                 cmd_stall,
	input  wire smqs_pkg::cmd_t                  cmd,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_stall,
	output smqs_pkg::rsp_t                       rsp,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [smqs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [smqs_pkg::CFG_DATA_W-1:0] cfg_data
);

	import smqs_pkg::*;

	logic accept;
	rsp_t result;

	assign cfg_ready = 1'b1;
	assign accept    = cmd_valid && !cmd_stall;

	smqs_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.cmd      (cmd),
		.result   (result)
	);

	smqs_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.result   (result),
		.cmd_stall(cmd_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

[rtl/smqs_ram.sv]
// smqs_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module smqs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

[rtl/smqs_core.sv]
// smqs_core: configuration registers, move queue and motor phase sequencer
// depends on smqs_pkg and smqs_ram
`default_nettype none

module smqs_core #(
	parameter int QUEUE_DEPTH = smqs_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [smqs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [smqs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                accept,
	input  wire smqs_pkg::cmd_t                      cmd,
	output smqs_pkg::rsp_t                           result
);

	import smqs_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HIGH,
		PH_LOW,
		PH_GAP
	} phase_t;

	logic [15:0]            half_q, gap_q;
	logic [11:0]            quarter_q;
	logic [CW-1:0]          qlen_q, qlen_d, slot_q, slot_d;
	logic                   run_q, run_d;
	phase_t                 phase_q, phase_d;
	logic [12:0]            steps_q, steps_d, steps_dec;
	logic [15:0]            tick_q, tick_d;
	logic [2:0]             motor_q, motor_d;
	logic [MOTOR_COUNT-1:0] dir_q, dir_d;
	logic                   byp_q;
	logic [CODE_W-1:0]      byp_data_q;

	logic [15:0]            hp;
	logic [11:0]            qs;
	logic [16:0]            tick_inc;
	logic                   hp_done, gap_done;
	logic [CODE_W-1:0]      head, rd_data;
	logic [MOTOR_COUNT-1:0] head_bit, cur_bit;
	logic                   wr_en, dropped;
	logic [AW-1:0]          wr_addr, rd_addr;
	logic                   rd_ok;
	logic [CW-1:0]          pend_full;

	smqs_ram #(
		.WIDTH(CODE_W),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(cmd.move_code),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		hp        = (half_q == 16'd0) ? 16'd1 : half_q;
		qs        = (quarter_q == 12'd0) ? 12'd1 : quarter_q;
		tick_inc  = {1'b0, tick_q} + 17'd1;
		hp_done   = tick_inc >= {1'b0, hp};
		gap_done  = tick_inc >= {1'b0, gap_q};
		// write in the same cycle as the head read: take the written code
		head      = byp_q ? byp_data_q : rd_data;
		head_bit  = motor_bit(code_motor(head));
		steps_dec = (steps_q != 13'd0) ? steps_q - 13'd1 : steps_q;
		wr_addr   = qlen_q[AW-1:0];

		qlen_d  = qlen_q;
		slot_d  = slot_q;
		run_d   = run_q;
		phase_d = phase_q;
		steps_d = steps_q;
		tick_d  = tick_q;
		motor_d = motor_q;
		dir_d   = dir_q;
		wr_en   = 1'b0;
		dropped = 1'b0;

		if (accept) begin
			case (cmd.kind)
				KIND_TICK: begin
					case (phase_q)
						PH_IDLE: begin
							if (run_q) begin
								if (slot_q < qlen_q) begin
									slot_d  = slot_q + CW'(1);
									motor_d = code_motor(head);
									dir_d   = code_dir(head) ? (dir_q | head_bit)
									                         : (dir_q & ~head_bit);
									steps_d = code_half(head) ? {qs, 1'b0} : {1'b0, qs};
									tick_d  = 16'd0;
									phase_d = PH_HIGH;
								end else begin
									// queue exhausted
									run_d = 1'b0;
								end
							end
						end
						PH_HIGH: begin
							if (hp_done) begin
								phase_d = PH_LOW;
								tick_d  = 16'd0;
							end else begin
								tick_d = tick_inc[15:0];
							end
						end
						PH_LOW: begin
							if (hp_done) begin
								tick_d  = 16'd0;
								steps_d = steps_dec;
								if (steps_dec != 13'd0) begin
									phase_d = PH_HIGH;
								end else begin
									phase_d = (gap_q != 16'd0) ? PH_GAP : PH_IDLE;
								end
							end else begin
								tick_d = tick_inc[15:0];
							end
						end
						PH_GAP: begin
							if (gap_done) begin
								phase_d = PH_IDLE;
								tick_d  = 16'd0;
							end else begin
								tick_d = tick_inc[15:0];
							end
						end
						default: begin
							phase_d = PH_IDLE;
						end
					endcase
				end
				KIND_PUSH: begin
					if (cmd.move_code == '0 || cmd.move_code > MAX_CODE
					    || qlen_q >= DEPTH_C) begin
						dropped = 1'b1;
					end else begin
						wr_en  = 1'b1;
						qlen_d = qlen_q + CW'(1);
					end
				end
				KIND_START: begin
					run_d = 1'b1;
				end
				KIND_STOP: begin
					run_d = 1'b0;
				end
				KIND_CLEAR: begin
					qlen_d = '0;
					slot_d = '0;
				end
				default: begin
				end
			endcase
		end

		// prefetch the code at the next head slot
		rd_ok   = slot_d < DEPTH_C;
		rd_addr = rd_ok ? slot_d[AW-1:0] : '0;

		cur_bit   = motor_bit(motor_d);
		pend_full = (qlen_d > slot_d) ? qlen_d - slot_d : '0;

		result.step_lines     = (phase_d == PH_HIGH) ? cur_bit : '0;
		result.dir_lines      = dir_d;
		result.enable_n_lines = (phase_d == PH_HIGH || phase_d == PH_LOW)
		                        ? ~cur_bit : ALL_MOTORS;
		result.running        = run_d;
		result.busy_res       = phase_d != PH_IDLE;
		result.pending_moves  = PEND_W'(pend_full);
		result.push_dropped   = dropped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q     <= HALF_PERIOD_RESET;
			gap_q      <= GAP_RESET;
			quarter_q  <= QUARTER_RESET;
			qlen_q     <= '0;
			slot_q     <= '0;
			run_q      <= 1'b0;
			phase_q    <= PH_IDLE;
			steps_q    <= '0;
			tick_q     <= '0;
			motor_q    <= '0;
			dir_q      <= '0;
			byp_q      <= 1'b0;
			byp_data_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_HALF_PERIOD: half_q    <= cfg_data;
					CFG_GAP:         gap_q     <= cfg_data;
					CFG_QUARTER:     quarter_q <= cfg_data[11:0];
					default: begin
					end
				endcase
			end
			qlen_q     <= qlen_d;
			slot_q     <= slot_d;
			run_q      <= run_d;
			phase_q    <= phase_d;
			steps_q    <= steps_d;
			tick_q     <= tick_d;
			motor_q    <= motor_d;
			dir_q      <= dir_d;
			byp_q      <= wr_en && rd_ok && (wr_addr == rd_addr);
			byp_data_q <= cmd.move_code;
		end
	end

endmodule

`default_nettype wire

[rtl/smqs_outbuf.sv]
// smqs_outbuf: result register plus skid register between the core and the result channel
// depends on smqs_pkg
`default_nettype none

module smqs_outbuf (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire smqs_pkg::rsp_t result,
	output logic                cmd_stall,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output smqs_pkg::rsp_t      rsp
);

	import smqs_pkg::*;

	logic skid_valid_q;
	rsp_t skid_q;
	logic take;

	assign cmd_stall = skid_valid_q;
	assign take      = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (accept) begin
				if (rsp_valid && !take) begin
					skid_valid_q <= 1'b1;
				end else begin
					rsp_valid <= 1'b1;
				end
			end else if (take) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				rsp <= skid_q;
			end
		end else if (accept) begin
			if (rsp_valid && !take) begin
				skid_q <= result;
			end else begin
				rsp <= result;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/smqs_checker.sv]
// smqs_checker: port-level checks for the stepper move queue sequencer, bound to the top level
// depends on smqs_pkg and stepper_move_queue_sequencer
`default_nettype none

module smqs_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           cmd_valid,
	input wire logic           cmd_stall,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire smqs_pkg::rsp_t rsp
);

	import smqs_pkg::*;

	// a stalled status request holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	// at most one motor is enabled at a time
	a_one_enable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot0(~rsp.enable_n_lines))
		else $error("more than one motor enabled");

	// a step pulse only on an enabled motor
	a_step_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.step_lines & rsp.enable_n_lines) == '0)
		else $error("step pulse on a disabled motor");

	// an enabled motor means a move is in progress
	a_enable_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.enable_n_lines != ALL_MOTORS |-> rsp.busy_res)
		else $error("motor enabled while not busy");

	// an accepted request always leaves rsp_valid high next cycle
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> rsp_valid)
		else $error("no status after an accepted request");

endmodule

bind stepper_move_queue_sequencer smqs_checker u_smqs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_stall(cmd_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

`default_nettype wire
